@@ rtl/core/dual_threshold_voice_detector_defines.svh @@
// Assertion macros shared by the voice detector RTL.
// Checks compile out when SYNTHESIS is defined.
`ifndef DUAL_THRESHOLD_VOICE_DETECTOR_DEFINES_SVH
`define DUAL_THRESHOLD_VOICE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DTVD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtvd check failed");
`define DTVD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtvd check failed");
`else
`define DTVD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DTVD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/dtvd_pkg.sv @@
// Types and constants of the voice detector.
// No dependencies.
package dtvd_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int ENERGY_W    = 41;
   localparam int CROSS_W     = 10;
   localparam int INDEX_W     = 16;
   localparam int HANG_W      = 8;
   localparam int LEN_W       = 11;
   localparam int HOP_W       = 10;
   localparam int CSR_W       = 41;
   localparam int CSR_IDX_W   = 3;
   localparam int SQ_W        = 31;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int HOP_MAX     = 1024;

   localparam logic [LEN_W-1:0]    RST_FRAME_LENGTH = 11'd400;
   localparam logic [LEN_W-1:0]    RST_HOP_LENGTH   = 11'd160;
   localparam logic [ENERGY_W-1:0] RST_ENERGY_HIGH  = 41'd1073741824;
   localparam logic [ENERGY_W-1:0] RST_ENERGY_LOW   = 41'd10737418;
   localparam logic [LEN_W-1:0]    RST_CROSS_THRESH = 11'd1024;
   localparam logic [HANG_W-1:0]   RST_HANGOVER     = 8'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_LENGTH = 3'd0,
      CSR_HOP_LENGTH   = 3'd1,
      CSR_ENERGY_HIGH  = 3'd2,
      CSR_ENERGY_LOW   = 3'd3,
      CSR_CROSS_THRESH = 3'd4,
      CSR_HANGOVER     = 3'd5
   } csr_index_type;

   // command waiting for history read data
   typedef struct packed {
      logic                       init;
      logic                       add;
      logic                       sub;
      logic                       emit;
      logic                       clear;
      logic                       from_mem;
      logic                       add_flag;
      logic                       new_flag;
      logic                       pad_cross;
      logic signed [SAMPLE_W-1:0] sample;
   } pend_type;

   // queued window update
   typedef struct packed {
      logic                       init;
      logic                       add;
      logic                       sub;
      logic                       emit;
      logic                       clear;
      logic                       cross_in;
      logic                       cross_out;
      logic                       pad_cross;
      logic signed [SAMPLE_W-1:0] new_sample;
      logic signed [SAMPLE_W-1:0] old_sample;
   } qent_type;

endpackage

@@ rtl/core/dtvd_front.sv @@
// Front end: accepts samples, keeps the sample history, times frames and
// issues window updates. Depends on dtvd_pkg.
`include "dual_threshold_voice_detector_defines.svh"
module dtvd_front #(
   parameter int MAX_FRAME = 1024,
   parameter int AW        = 10,
   parameter int FW        = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dtvd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last,
   input  logic [FW-1:0]                       frame_len,
   input  logic [dtvd_pkg::LEN_W-1:0]          hop_len,
   input  logic                                frame_wr,
   input  logic [FW-1:0]                       frame_new,
   input  logic [dtvd_pkg::QCNT_W-1:0]         q_count,
   output logic                                push,
   output dtvd_pkg::qent_type                  push_data
);

   localparam logic [AW:0] MAXX = (AW + 1)'(MAX_FRAME);
   localparam int EW = dtvd_pkg::SAMPLE_W + 1;

   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p,
                                               input logic [FW-1:0] d);
      logic [AW:0] px;
      logic [AW:0] dx;
      logic [AW:0] r;
      px = (AW + 1)'(p);
      dx = (AW + 1)'(d);
      r  = (px >= dx) ? px - dx : px + MAXX - dx;
      return r[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      return (p == AW'(MAX_FRAME - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [EW-1:0] mem [MAX_FRAME];
   logic [EW-1:0] rd_a_ff, rd_b_ff;

   logic [AW-1:0] wp_ff, wp_in;
   logic          last_neg_ff, last_neg_in;
   logic [FW-1:0] seen_ff, seen_in;
   logic [dtvd_pkg::HOP_W-1:0] hop_phase_ff, hop_phase_in;
   logic          emitted_ff, emitted_in;
   logic [FW-1:0] win_cnt_ff, win_cnt_in;
   logic          rc_active_ff, rc_active_in;
   logic [FW-1:0] rc_left_ff, rc_left_in;
   logic [AW-1:0] rc_addr_ff, rc_addr_in;
   logic          rc_first_ff, rc_first_in;
   logic          f1_valid_ff, f1_valid_in;
   dtvd_pkg::pend_type f1_ff, f1_in;

   logic          room, accept, rc_issue;
   logic [AW-1:0] addr_a, addr_b, rd_addr;
   logic          neg, full, emit_f;
   logic [FW-1:0] seen_n, rc_len;
   logic [dtvd_pkg::LEN_W-1:0] hop_next;

   assign room = ({1'b0, q_count} + {{dtvd_pkg::QCNT_W{1'b0}}, f1_valid_ff})
                 < (dtvd_pkg::QCNT_W + 1)'(dtvd_pkg::QUEUE_DEPTH);
   assign req_ready = !rc_active_ff && room;
   assign accept    = req_valid && req_ready;
   assign rc_issue  = rc_active_ff && room;

   assign addr_a  = ring_back(wp_ff, frame_len);
   assign addr_b  = ring_next(addr_a);
   assign rd_addr = rc_active_ff ? rc_addr_ff : addr_a;

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_ff] <= {req_sample[dtvd_pkg::SAMPLE_W-1] ^ last_neg_ff, req_sample};
      end
      rd_a_ff <= mem[rd_addr];
      rd_b_ff <= mem[addr_b];
   end

   always_comb begin
      neg      = req_sample[dtvd_pkg::SAMPLE_W-1];
      full     = (win_cnt_ff == frame_len);
      seen_n   = (seen_ff == FW'(MAX_FRAME)) ? seen_ff : seen_ff + 1'b1;
      hop_next = {1'b0, hop_phase_ff} + 1'b1;
      emit_f   = emitted_ff ? (hop_next >= hop_len) : (seen_n >= frame_len);
      rc_len   = emitted_ff ? frame_new : ((seen_ff < frame_new) ? seen_ff : frame_new);

      wp_in        = wp_ff;
      last_neg_in  = last_neg_ff;
      seen_in      = seen_ff;
      hop_phase_in = hop_phase_ff;
      emitted_in   = emitted_ff;
      win_cnt_in   = win_cnt_ff;
      rc_active_in = rc_active_ff;
      rc_left_in   = rc_left_ff;
      rc_addr_in   = rc_addr_ff;
      rc_first_in  = rc_first_ff;
      f1_valid_in  = accept || rc_issue;
      f1_in        = '0;

      if (accept) begin
         wp_in        = ring_next(wp_ff);
         last_neg_in  = neg;
         seen_in      = seen_n;
         win_cnt_in   = full ? win_cnt_ff : win_cnt_ff + 1'b1;
         emitted_in   = emitted_ff || emit_f;
         if (emit_f) begin
            hop_phase_in = '0;
         end else if (emitted_ff) begin
            hop_phase_in = hop_next[dtvd_pkg::HOP_W-1:0];
         end
         f1_in.add       = 1'b1;
         f1_in.sub       = full;
         f1_in.emit      = emit_f || (req_last && !emitted_ff);
         f1_in.clear     = req_last;
         f1_in.add_flag  = (win_cnt_ff != '0);
         f1_in.new_flag  = neg ^ last_neg_ff;
         f1_in.pad_cross = req_last && !emit_f && !emitted_ff && neg;
         f1_in.sample    = req_sample;
         if (req_last) begin
            seen_in      = '0;
            hop_phase_in = '0;
            emitted_in   = 1'b0;
            win_cnt_in   = '0;
         end
      end

      if (rc_issue) begin
         f1_in.init     = rc_first_ff;
         f1_in.add      = (rc_left_ff != '0);
         f1_in.from_mem = 1'b1;
         f1_in.add_flag = !rc_first_ff;
         rc_first_in    = 1'b0;
         if (rc_left_ff != '0) begin
            rc_left_in = rc_left_ff - 1'b1;
            rc_addr_in = ring_next(rc_addr_ff);
         end
         if (rc_left_ff <= FW'(1)) begin
            rc_active_in = 1'b0;
         end
      end

      if (frame_wr) begin
         rc_active_in = 1'b1;
         rc_left_in   = rc_len;
         rc_addr_in   = ring_back(wp_ff, rc_len);
         rc_first_in  = 1'b1;
         win_cnt_in   = rc_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         last_neg_ff  <= 1'b0;
         seen_ff      <= '0;
         hop_phase_ff <= '0;
         emitted_ff   <= 1'b0;
         win_cnt_ff   <= '0;
         rc_active_ff <= 1'b0;
         rc_left_ff   <= '0;
         rc_addr_ff   <= '0;
         rc_first_ff  <= 1'b0;
         f1_valid_ff  <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         last_neg_ff  <= last_neg_in;
         seen_ff      <= seen_in;
         hop_phase_ff <= hop_phase_in;
         emitted_ff   <= emitted_in;
         win_cnt_ff   <= win_cnt_in;
         rc_active_ff <= rc_active_in;
         rc_left_ff   <= rc_left_in;
         rc_addr_ff   <= rc_addr_in;
         rc_first_ff  <= rc_first_in;
         f1_valid_ff  <= f1_valid_in;
      end
      f1_ff <= f1_in;
   end

   always_comb begin
      push                 = f1_valid_ff;
      push_data.init       = f1_ff.init;
      push_data.add        = f1_ff.add;
      push_data.sub        = f1_ff.sub;
      push_data.emit       = f1_ff.emit;
      push_data.clear      = f1_ff.clear;
      push_data.pad_cross  = f1_ff.pad_cross;
      push_data.new_sample = f1_ff.from_mem ? rd_a_ff[dtvd_pkg::SAMPLE_W-1:0] : f1_ff.sample;
      push_data.cross_in   = f1_ff.add_flag &&
                             (f1_ff.from_mem ? rd_a_ff[EW-1] : f1_ff.new_flag);
      push_data.old_sample = rd_a_ff[dtvd_pkg::SAMPLE_W-1:0];
      push_data.cross_out  = f1_ff.sub && rd_b_ff[EW-1];
   end

   `DTVD_ASSERT_IMP(a_win_in_frame, clock, reset, 1'b1, win_cnt_ff <= frame_len)
   `DTVD_ASSERT_IMP(a_no_accept_in_pass, clock, reset, rc_active_ff, !req_ready)

endmodule

@@ rtl/core/dtvd_queue.sv @@
// Short command queue between front and back end.
// Depends on dtvd_pkg.
`include "dual_threshold_voice_detector_defines.svh"
module dtvd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  dtvd_pkg::qent_type          push_data,
   input  logic                        pop,
   output logic                        q_valid,
   output dtvd_pkg::qent_type          q_data,
   output logic [dtvd_pkg::QCNT_W-1:0] q_count
);

   dtvd_pkg::qent_type slots_ff [dtvd_pkg::QUEUE_DEPTH];
   logic [dtvd_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [dtvd_pkg::QCNT_W-1:0] count_ff;
   logic do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign q_valid = (count_ff != '0);
   assign q_data  = slots_ff[rd_ff];
   assign q_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + {{(dtvd_pkg::QCNT_W-1){1'b0}}, push}
                              - {{(dtvd_pkg::QCNT_W-1){1'b0}}, do_pop};
      end
      if (push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

   `DTVD_ASSERT_IMP(a_no_overflow, clock, reset, push,
      count_ff != dtvd_pkg::QCNT_W'(dtvd_pkg::QUEUE_DEPTH) || do_pop)

endmodule

@@ rtl/core/dtvd_back.sv @@
// Back end: window sums, speech decision with hangover, result register.
// Depends on dtvd_pkg.
`include "dual_threshold_voice_detector_defines.svh"
module dtvd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  dtvd_pkg::qent_type                  q_data,
   output logic                                pop,
   input  logic [dtvd_pkg::ENERGY_W-1:0]       energy_high,
   input  logic [dtvd_pkg::ENERGY_W-1:0]       energy_low,
   input  logic [dtvd_pkg::LEN_W-1:0]          cross_thresh,
   input  logic [dtvd_pkg::HANG_W-1:0]         hangover,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_speech,
   output logic [dtvd_pkg::ENERGY_W-1:0]       rsp_frame_energy_sum,
   output logic [dtvd_pkg::CROSS_W-1:0]        rsp_crossing_count,
   output logic [dtvd_pkg::INDEX_W-1:0]        rsp_frame_index
);

   dtvd_pkg::qent_type b1_ff;
   logic b1_valid_ff;
   logic [dtvd_pkg::SQ_W-1:0] sq_new_ff, sq_old_ff;
   logic [dtvd_pkg::ENERGY_W-1:0] sum_ff, sum_in;
   logic [dtvd_pkg::CROSS_W-1:0]  cross_ff, cross_in;
   logic [dtvd_pkg::HANG_W-1:0]   hang_ff, hang_in;
   logic [dtvd_pkg::INDEX_W-1:0]  fc_ff;
   logic rsp_valid_ff;
   logic [dtvd_pkg::ENERGY_W-1:0] out_sum_ff;
   logic [dtvd_pkg::CROSS_W-1:0]  out_cross_ff;
   logic [dtvd_pkg::INDEX_W-1:0]  out_index_ff;
   logic out_speech_ff;
   logic b1_fire, speech;
   logic signed [2*dtvd_pkg::SAMPLE_W-1:0] prod_new, prod_old;

   assign b1_fire = b1_valid_ff && (!b1_ff.emit || !rsp_valid_ff || rsp_ready);
   assign pop     = q_valid && (!b1_valid_ff || b1_fire);
   assign prod_new = q_data.new_sample * q_data.new_sample;
   assign prod_old = q_data.old_sample * q_data.old_sample;

   always_comb begin
      sum_in = (b1_ff.init ? '0 : sum_ff)
             + (b1_ff.add ? dtvd_pkg::ENERGY_W'(sq_new_ff) : '0)
             - (b1_ff.sub ? dtvd_pkg::ENERGY_W'(sq_old_ff) : '0);
      cross_in = (b1_ff.init ? '0 : cross_ff)
               + dtvd_pkg::CROSS_W'(b1_ff.cross_in)
               + dtvd_pkg::CROSS_W'(b1_ff.pad_cross)
               - dtvd_pkg::CROSS_W'(b1_ff.cross_out);
      speech  = 1'b0;
      hang_in = hang_ff;
      if (sum_in >= energy_high) begin
         speech  = 1'b1;
         hang_in = hangover;
      end else if (sum_in >= energy_low) begin
         if (hang_ff != '0) begin
            speech  = 1'b1;
            hang_in = hang_ff - 1'b1;
         end else if ({1'b0, cross_in} >= cross_thresh) begin
            speech  = 1'b1;
            hang_in = hangover >> 1;
         end
      end else if (hang_ff != '0) begin
         speech  = 1'b1;
         hang_in = hang_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         cross_ff     <= '0;
         hang_ff      <= '0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            b1_valid_ff <= 1'b1;
         end else if (b1_fire) begin
            b1_valid_ff <= 1'b0;
         end
         if (b1_fire && b1_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (b1_fire) begin
            if (b1_ff.clear) begin
               sum_ff   <= '0;
               cross_ff <= '0;
               hang_ff  <= '0;
               fc_ff    <= '0;
            end else begin
               sum_ff   <= sum_in;
               cross_ff <= cross_in;
               if (b1_ff.emit) begin
                  hang_ff <= hang_in;
                  fc_ff   <= fc_ff + 1'b1;
               end
            end
         end
      end
      if (pop) begin
         b1_ff     <= q_data;
         sq_new_ff <= prod_new[dtvd_pkg::SQ_W-1:0];
         sq_old_ff <= prod_old[dtvd_pkg::SQ_W-1:0];
      end
      if (b1_fire && b1_ff.emit) begin
         out_speech_ff <= speech;
         out_sum_ff    <= sum_in;
         out_cross_ff  <= cross_in;
         out_index_ff  <= fc_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_speech           = out_speech_ff;
   assign rsp_frame_energy_sum = out_sum_ff;
   assign rsp_crossing_count   = out_cross_ff;
   assign rsp_frame_index      = out_index_ff;

   `DTVD_ASSERT_NEXT(a_emit_shows, clock, reset, b1_fire && b1_ff.emit, rsp_valid_ff)

endmodule

@@ rtl/core/dual_threshold_voice_detector.sv @@
// Dual-threshold voice activity detector, top level: config registers and
// wiring of dtvd_front, dtvd_queue and dtvd_back. Depends on dtvd_pkg.
//
// Takes one audio sample per clock while req_ready is high and keeps sliding
// sums of energy and sign changes, updated by one history write and two
// history reads per sample, so the sustained rate is one item per cycle
// without stalls; a result passes the front, queue, back-end and result
// registers. Writing frame_length starts a rebuild of the window sums that
// reads the history once per cycle while the queue has room; req_ready stays
// low until every sample of the new window (at most frame_length) is read.
module dual_threshold_voice_detector #(
   parameter int MAX_FRAME = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [dtvd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_speech,
   output logic [dtvd_pkg::ENERGY_W-1:0]        rsp_frame_energy_sum,
   output logic [dtvd_pkg::CROSS_W-1:0]         rsp_crossing_count,
   output logic [dtvd_pkg::INDEX_W-1:0]         rsp_frame_index,
   input  logic                                 csr_we,
   input  logic [dtvd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtvd_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam int FW = $clog2(MAX_FRAME + 1);

   function automatic logic [FW-1:0] clamp_frame(input logic [dtvd_pkg::LEN_W-1:0] x);
      logic [FW-1:0] r;
      if (x < dtvd_pkg::LEN_W'(2)) begin
         r = FW'(2);
      end else if (int'(x) > MAX_FRAME) begin
         r = FW'(MAX_FRAME);
      end else begin
         r = FW'(x);
      end
      return r;
   endfunction

   logic [dtvd_pkg::LEN_W-1:0]    frame_length_ff;
   logic [dtvd_pkg::LEN_W-1:0]    hop_length_ff;
   logic [dtvd_pkg::ENERGY_W-1:0] energy_high_ff;
   logic [dtvd_pkg::ENERGY_W-1:0] energy_low_ff;
   logic [dtvd_pkg::LEN_W-1:0]    cross_thresh_ff;
   logic [dtvd_pkg::HANG_W-1:0]   hangover_ff;

   logic [FW-1:0]                 frame_eff, frame_new;
   logic [dtvd_pkg::LEN_W-1:0]    hop_eff;
   logic                          frame_wr;
   logic                          push, pop, q_valid;
   dtvd_pkg::qent_type            push_data, q_data;
   logic [dtvd_pkg::QCNT_W-1:0]   q_count;

   assign frame_eff = clamp_frame(frame_length_ff);
   assign frame_new = clamp_frame(csr_wdata[dtvd_pkg::LEN_W-1:0]);
   assign frame_wr  = csr_we && (csr_index == dtvd_pkg::CSR_FRAME_LENGTH);
   assign hop_eff   = (hop_length_ff == '0) ? dtvd_pkg::LEN_W'(1) :
                      (hop_length_ff > dtvd_pkg::LEN_W'(dtvd_pkg::HOP_MAX)) ?
                      dtvd_pkg::LEN_W'(dtvd_pkg::HOP_MAX) : hop_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= dtvd_pkg::RST_FRAME_LENGTH;
         hop_length_ff   <= dtvd_pkg::RST_HOP_LENGTH;
         energy_high_ff  <= dtvd_pkg::RST_ENERGY_HIGH;
         energy_low_ff   <= dtvd_pkg::RST_ENERGY_LOW;
         cross_thresh_ff <= dtvd_pkg::RST_CROSS_THRESH;
         hangover_ff     <= dtvd_pkg::RST_HANGOVER;
      end else if (csr_we) begin
         unique case (csr_index)
            dtvd_pkg::CSR_FRAME_LENGTH: frame_length_ff <= csr_wdata[dtvd_pkg::LEN_W-1:0];
            dtvd_pkg::CSR_HOP_LENGTH:   hop_length_ff   <= csr_wdata[dtvd_pkg::LEN_W-1:0];
            dtvd_pkg::CSR_ENERGY_HIGH:  energy_high_ff  <= csr_wdata;
            dtvd_pkg::CSR_ENERGY_LOW:   energy_low_ff   <= csr_wdata;
            dtvd_pkg::CSR_CROSS_THRESH: cross_thresh_ff <= csr_wdata[dtvd_pkg::LEN_W-1:0];
            dtvd_pkg::CSR_HANGOVER:     hangover_ff     <= csr_wdata[dtvd_pkg::HANG_W-1:0];
            default: ;
         endcase
      end
   end

   dtvd_front #(
      .MAX_FRAME (MAX_FRAME),
      .AW        (AW),
      .FW        (FW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .frame_len  (frame_eff),
      .hop_len    (hop_eff),
      .frame_wr   (frame_wr),
      .frame_new  (frame_new),
      .q_count    (q_count),
      .push       (push),
      .push_data  (push_data)
   );

   dtvd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_count   (q_count)
   );

   dtvd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_data               (q_data),
      .pop                  (pop),
      .energy_high          (energy_high_ff),
      .energy_low           (energy_low_ff),
      .cross_thresh         (cross_thresh_ff),
      .hangover             (hangover_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_speech           (rsp_speech),
      .rsp_frame_energy_sum (rsp_frame_energy_sum),
      .rsp_crossing_count   (rsp_crossing_count),
      .rsp_frame_index      (rsp_frame_index)
   );

endmodule

@@ dv/tb_dual_threshold_voice_detector.sv @@
// Testbench for dual_threshold_voice_detector: directed table, then random streams,
// checked item by item against an in-bench frame predictor. Depends on dtvd_pkg.
`timescale 1ns / 1ps
module tb_dual_threshold_voice_detector;

   typedef struct packed {
      logic                          speech;
      logic [dtvd_pkg::ENERGY_W-1:0] energy;
      logic [dtvd_pkg::CROSS_W-1:0]  crossings;
      logic [dtvd_pkg::INDEX_W-1:0]  index;
   } frame_result_type;

   typedef struct packed {
      logic signed [dtvd_pkg::SAMPLE_W-1:0] smp;
      logic                                 last;
      logic                                 typed;
      frame_result_type                     res;
   } vad_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [dtvd_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                 req_last = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic                                 rsp_speech;
   logic [dtvd_pkg::ENERGY_W-1:0]        rsp_frame_energy_sum;
   logic [dtvd_pkg::CROSS_W-1:0]         rsp_crossing_count;
   logic [dtvd_pkg::INDEX_W-1:0]         rsp_frame_index;
   logic                                 csr_we = 1'b0;
   logic [dtvd_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [dtvd_pkg::CSR_W-1:0]           csr_wdata = '0;

   dual_threshold_voice_detector i_dut (.*);

   always #1 clock = ~clock;

   // frame predictor state
   int unsigned                          frame_len_reg, hop_len_reg, cross_thr_reg, hang_reg;
   logic [dtvd_pkg::ENERGY_W-1:0]        high_thr_reg, low_thr_reg;
   logic signed [dtvd_pkg::SAMPLE_W-1:0] history [1024];
   int unsigned                          wr_ptr, seen_cnt, hop_ph, hang_left, frame_cnt;
   bit                                   frame_done;

   frame_result_type expected_frames [$];
   int  errors = 0;
   int  max_gap = 6;
   bit  long_hold = 0;
   int  idle_cycles = 0;

   function automatic void clear_stream();
      seen_cnt = 0; hop_ph = 0; hang_left = 0; frame_cnt = 0; frame_done = 0;
   endfunction

   function automatic frame_result_type judge_frame(int unsigned cnt, bit pad);
      frame_result_type r;
      logic [63:0] acc = 0;
      int unsigned zc = 0;
      bit prev_neg = 0, neg;
      int v;
      for (int unsigned i = 0; i < cnt; i++) begin
         v = history[(wr_ptr + 2048 - cnt + i) % 1024];
         neg = v < 0;
         acc += 64'(longint'(v) * longint'(v));
         if (i > 0 && neg != prev_neg) zc++;
         prev_neg = neg;
      end
      if (pad && cnt > 0 && prev_neg) zc++;
      r.energy = acc[dtvd_pkg::ENERGY_W-1:0];
      r.crossings = zc[dtvd_pkg::CROSS_W-1:0];
      r.speech = 0;
      if (r.energy >= high_thr_reg) begin
         r.speech = 1; hang_left = hang_reg;
      end else if (r.energy >= low_thr_reg) begin
         if (hang_left > 0) begin
            r.speech = 1; hang_left--;
         end else if (zc >= cross_thr_reg) begin
            r.speech = 1; hang_left = hang_reg / 2;
         end
      end else if (hang_left > 0) begin
         r.speech = 1; hang_left--;
      end
      r.index = frame_cnt[dtvd_pkg::INDEX_W-1:0];
      frame_cnt = (frame_cnt + 1) & 16'hFFFF;
      frame_done = 1;
      return r;
   endfunction

   function automatic bit predict_frame(logic signed [dtvd_pkg::SAMPLE_W-1:0] s, bit last,
                                        output frame_result_type r);
      int unsigned f, h;
      bit got = 0;
      f = frame_len_reg < 2 ? 2 : (frame_len_reg > 1024 ? 1024 : frame_len_reg);
      h = hop_len_reg < 1 ? 1 : (hop_len_reg > 1024 ? 1024 : hop_len_reg);
      history[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % 1024;
      if (seen_cnt < 1024) seen_cnt++;
      if (!frame_done) begin
         if (seen_cnt >= f) begin
            r = judge_frame(f, 0); hop_ph = 0; got = 1;
         end
      end else if (hop_ph + 1 >= h) begin
         r = judge_frame(f, 0); hop_ph = 0; got = 1;
      end else begin
         hop_ph++;
      end
      if (last) begin
         if (!got && !frame_done) begin
            r = judge_frame(seen_cnt, 1); got = 1;
         end
         clear_stream();
      end
      return got;
   endfunction

   task automatic csr_write(dtvd_pkg::csr_index_type idx, logic [dtvd_pkg::CSR_W-1:0] v);
      csr_we = 1; csr_index = idx; csr_wdata = v;
      case (idx)
         dtvd_pkg::CSR_FRAME_LENGTH: frame_len_reg = v[10:0];
         dtvd_pkg::CSR_HOP_LENGTH:   hop_len_reg = v[10:0];
         dtvd_pkg::CSR_ENERGY_HIGH:  high_thr_reg = v[dtvd_pkg::ENERGY_W-1:0];
         dtvd_pkg::CSR_ENERGY_LOW:   low_thr_reg = v[dtvd_pkg::ENERGY_W-1:0];
         dtvd_pkg::CSR_CROSS_THRESH: cross_thr_reg = v[10:0];
         dtvd_pkg::CSR_HANGOVER:     hang_reg = v[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic send_sample(logic signed [dtvd_pkg::SAMPLE_W-1:0] s, bit last, bit typed,
                              frame_result_type ty);
      frame_result_type r;
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1; req_sample = s; req_last = last;
      do @(posedge clock); while (!req_ready);
      if (predict_frame(s, last, r)) expected_frames.push_back(typed ? ty : r);
      else if (typed) expected_frames.push_back(ty);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      while (expected_frames.size() > 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   function automatic logic signed [dtvd_pkg::SAMPLE_W-1:0] pick_sample(bit alt, int i);
      logic signed [dtvd_pkg::SAMPLE_W-1:0] s;
      case ($urandom_range(0, 6))
         0: s = 16'sh7FFF;
         1: s = -16'sh8000;
         2: s = 16'sd0;
         3: s = -16'sd1;
         4: s = 16'($urandom_range(0, 400));
         default: s = 16'($urandom);
      endcase
      if (alt) s = (i % 2) ? 16'(-int'($urandom_range(1, 32767))) :
                             16'($urandom_range(0, 32767));
      return s;
   endfunction

   // result checker
   always @(posedge clock) begin
      frame_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            errors++;
            $display("%0t: unexpected frame, speech %0b energy %0d crossings %0d index %0d",
                     $time, rsp_speech, rsp_frame_energy_sum, rsp_crossing_count,
                     rsp_frame_index);
         end else begin
            e = expected_frames.pop_front();
            if (rsp_speech !== e.speech) begin
               errors++;
               $display("%0t: speech exp %0b got %0b", $time, e.speech, rsp_speech);
            end
            if (rsp_frame_energy_sum !== e.energy) begin
               errors++;
               $display("%0t: energy exp %0d got %0d", $time, e.energy, rsp_frame_energy_sum);
            end
            if (rsp_crossing_count !== e.crossings) begin
               errors++;
               $display("%0t: crossings exp %0d got %0d", $time, e.crossings,
                        rsp_crossing_count);
            end
            if (rsp_frame_index !== e.index) begin
               errors++;
               $display("%0t: index exp %0d got %0d", $time, e.index, rsp_frame_index);
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready = 0;
            long_hold = 0;
            repeat (200) @(negedge clock);
         end
         gap = $urandom_range(0, max_gap);
         if (gap > 0) begin
            rsp_ready = 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb: failure");
         $finish;
      end
   end

   vad_row_type directed [] = '{
      '{16'sh7FFF,  1'b0, 1'b0, '0},
      '{-16'sh8000, 1'b0, 1'b1, '{1'b1, 41'd2147418113, 10'd1, 16'd0}},
      '{16'sh0000,  1'b0, 1'b1, '{1'b1, 41'd1073741824, 10'd1, 16'd1}},
      '{16'sh0000,  1'b0, 1'b0, '0},
      '{-16'sh0001, 1'b1, 1'b0, '0},
      '{-16'sh0005, 1'b1, 1'b1, '{1'b0, 41'd25, 10'd1, 16'd0}},
      '{16'sh0064,  1'b1, 1'b1, '{1'b0, 41'd10000, 10'd0, 16'd0}},
      '{16'sh0001,  1'b0, 1'b0, '0},
      '{-16'sh0001, 1'b0, 1'b0, '0},
      '{16'sh0001,  1'b0, 1'b0, '0},
      '{16'sh0000,  1'b0, 1'b0, '0},
      '{16'sh4000,  1'b0, 1'b0, '0},
      '{-16'sh4000, 1'b0, 1'b0, '0},
      '{16'sh0000,  1'b1, 1'b0, '0}
   };

   initial begin
      int unsigned f, slen, small_items, phase;
      logic [63:0] span;
      bit alt;
      frame_line_init: begin
         frame_len_reg = dtvd_pkg::RST_FRAME_LENGTH; hop_len_reg = dtvd_pkg::RST_HOP_LENGTH;
         high_thr_reg = dtvd_pkg::RST_ENERGY_HIGH; low_thr_reg = dtvd_pkg::RST_ENERGY_LOW;
         cross_thr_reg = dtvd_pkg::RST_CROSS_THRESH; hang_reg = dtvd_pkg::RST_HANGOVER;
         wr_ptr = 0; clear_stream();
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset thresholds, shortest frame
      csr_write(dtvd_pkg::CSR_FRAME_LENGTH, 2);
      csr_write(dtvd_pkg::CSR_HOP_LENGTH, 1);
      foreach (directed[i])
         send_sample(directed[i].smp, directed[i].last, directed[i].typed, directed[i].res);
      drain();
      // crossing test always met, no hangover, out-of-range lengths
      csr_write(dtvd_pkg::CSR_FRAME_LENGTH, 0);
      csr_write(dtvd_pkg::CSR_HOP_LENGTH, 0);
      csr_write(dtvd_pkg::CSR_CROSS_THRESH, 0);
      csr_write(dtvd_pkg::CSR_HANGOVER, 0);
      csr_write(dtvd_pkg::CSR_ENERGY_LOW, 0);
      csr_write(dtvd_pkg::CSR_ENERGY_HIGH, {dtvd_pkg::CSR_W{1'b1}});
      for (int i = 0; i < 6; i++) send_sample(i[0] ? -16'sh0003 : 16'sh0003, i == 5, 0, '0);
      drain();

      small_items = 0;
      phase = 0;
      while (small_items < 760) begin
         case ($urandom_range(0, 7))
            0: csr_write(dtvd_pkg::CSR_FRAME_LENGTH, $urandom_range(0, 1));
            default: csr_write(dtvd_pkg::CSR_FRAME_LENGTH, $urandom_range(2, 24));
         endcase
         case ($urandom_range(0, 7))
            0: csr_write(dtvd_pkg::CSR_HOP_LENGTH, 0);
            1: csr_write(dtvd_pkg::CSR_HOP_LENGTH, 2047);
            default: csr_write(dtvd_pkg::CSR_HOP_LENGTH, $urandom_range(1, 28));
         endcase
         if (phase == 2) begin
            csr_write(dtvd_pkg::CSR_FRAME_LENGTH, 2);
            csr_write(dtvd_pkg::CSR_HOP_LENGTH, 1);
         end
         f = frame_len_reg < 2 ? 2 : frame_len_reg;
         span = 64'(f) << 30;
         csr_write(dtvd_pkg::CSR_ENERGY_HIGH,
                   $urandom_range(0, 7) == 0 ? {dtvd_pkg::CSR_W{1'b1}} :
                   ($urandom_range(0, 7) == 0 ? 41'd0 : 41'(span / $urandom_range(1, 16))));
         csr_write(dtvd_pkg::CSR_ENERGY_LOW,
                   $urandom_range(0, 7) == 0 ? {dtvd_pkg::CSR_W{1'b1}} :
                   41'(span / $urandom_range(4, 4096)));
         csr_write(dtvd_pkg::CSR_CROSS_THRESH,
                   $urandom_range(0, 5) == 0 ? 2047 : $urandom_range(0, f));
         csr_write(dtvd_pkg::CSR_HANGOVER,
                   $urandom_range(0, 5) == 0 ? 255 : $urandom_range(0, 6));
         max_gap = ($urandom_range(0, 3) == 0 || phase == 2) ? 0 : 6;
         if (phase == 2) long_hold = 1;
         repeat ($urandom_range(1, 4)) begin
            slen = $urandom_range(0, 3) == 0 ? $urandom_range(1, f) :
                   $urandom_range(f, 3 * f + 10);
            alt = $urandom_range(0, 2) == 0;
            for (int i = 0; i < slen; i++)
               send_sample(pick_sample(alt, i), i == slen - 1, 0, '0);
            small_items += slen;
         end
         drain();
         phase++;
      end

      // longest frame
      max_gap = 6;
      csr_write(dtvd_pkg::CSR_FRAME_LENGTH, 2047);
      csr_write(dtvd_pkg::CSR_HOP_LENGTH, 40);
      csr_write(dtvd_pkg::CSR_ENERGY_HIGH, 41'h100_0000_0000);
      csr_write(dtvd_pkg::CSR_ENERGY_LOW, 41'd1 << 30);
      csr_write(dtvd_pkg::CSR_CROSS_THRESH, 512);
      for (int i = 0; i < 1100; i++) send_sample(pick_sample(i > 700, i), i == 1099, 0, '0);
      drain();
      csr_write(dtvd_pkg::CSR_FRAME_LENGTH, 1024);
      for (int i = 0; i < 7; i++) send_sample(pick_sample(0, i), i == 6, 0, '0);
      drain();

      if (errors == 0 && expected_frames.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
